>>> rtl/bsd_pkg.sv
package bsd_pkg;

    localparam int QueueDepth = 4;
    localparam int QueuePtrW  = $clog2(QueueDepth);

    typedef enum logic [2:0] {
        ST_DATA       = 3'd0,
        ST_END_OK     = 3'd1,
        ST_BAD_SYMBOL = 3'd2,
        ST_BAD_PAD    = 3'd3,
        ST_BAD_END    = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        CLS_VALUE   = 2'd0,
        CLS_PAD     = 2'd1,
        CLS_SKIP    = 2'd2,
        CLS_INVALID = 2'd3
    } char_class_t;

    typedef enum logic [1:0] {
        PAD_NONE = 2'd0,
        PAD_ONE  = 2'd1,
        PAD_TWO  = 2'd2
    } pad_mode_t;

    typedef struct packed {
        char_class_t cls;
        logic [5:0]  val;
    } class_res_t;

    // one queue entry: the results caused by one character
    typedef struct packed {
        logic [23:0] bytes;
        logic [1:0]  nbytes;
        logic        has_end;
        status_t     end_status;
    } job_t;

    typedef struct packed {
        logic push;
        job_t job;
    } q_wr_t;

    typedef struct packed {
        logic empty;
        logic full;
        job_t head;
    } q_rd_t;

    typedef struct packed {
        logic accept;
        logic discarding;
    } front_stat_t;

    function automatic class_res_t classify(input logic [7:0] c);
        class_res_t r;
        r.cls = CLS_INVALID;
        r.val = 6'd0;
        if (c >= 8'h41 && c <= 8'h5A) begin
            r.cls = CLS_VALUE;
            r.val = 6'(c - 8'h41);
        end
        else if (c >= 8'h61 && c <= 8'h7A) begin
            r.cls = CLS_VALUE;
            r.val = 6'(c - 8'h61 + 8'd26);
        end
        else if (c >= 8'h30 && c <= 8'h39) begin
            r.cls = CLS_VALUE;
            r.val = 6'(c - 8'h30 + 8'd52);
        end
        else if (c == 8'h2B) begin
            r.cls = CLS_VALUE;
            r.val = 6'd62;
        end
        else if (c == 8'h2F) begin
            r.cls = CLS_VALUE;
            r.val = 6'd63;
        end
        else if (c == 8'h3D) begin
            r.cls = CLS_PAD;
        end
        else if (c == 8'h20 || c == 8'h09 || c == 8'h0A || c == 8'h0D) begin
            r.cls = CLS_SKIP;
        end
        return r;
    endfunction

endpackage

>>> rtl/bsd_if.sv
interface bsd_sym_if;
    logic       valid;
    logic       ready;
    logic [7:0] symbol;
    logic       final_req;

    modport source (output valid, output symbol, output final_req, input ready);
    modport sink (input valid, input symbol, input final_req, output ready);
endinterface

interface bsd_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [2:0] status;
    logic       last_of_run;

    modport source (output valid, output out_byte, output status, output last_of_run,
                    input ready);
    modport sink (input valid, input out_byte, input status, input last_of_run,
                  output ready);
endinterface

>>> rtl/bsd_front.sv
module bsd_front (
    input  logic                 clk,
    input  logic                 rst_n,
    bsd_sym_if.sink              chars,
    input  bsd_pkg::q_rd_t       q_rd,
    output bsd_pkg::q_wr_t       q_wr,
    output bsd_pkg::front_stat_t stat
);
    import bsd_pkg::*;

    logic [23:0] acc_reg, acc_next;
    logic [1:0]  pos_reg, pos_next;
    pad_mode_t   pad_reg, pad_next;
    logic        disc_reg, disc_next;

    logic       accept;
    class_res_t cr;
    logic       pad_err;
    logic [23:0] acc_shift;

    assign chars.ready = !q_rd.full;
    assign accept      = chars.valid && chars.ready;
    assign cr          = classify(chars.symbol);
    assign acc_shift   = {acc_reg[17:0], cr.val};

    always_comb
    begin
        acc_next  = acc_reg;
        pos_next  = pos_reg;
        pad_next  = pad_reg;
        disc_next = disc_reg;
        pad_err   = 1'b0;
        q_wr.push = 1'b0;
        q_wr.job  = '{bytes: acc_shift, nbytes: 2'd0, has_end: 1'b0, end_status: ST_END_OK};

        if (accept) begin
            if (disc_reg) begin
                if (chars.final_req) begin
                    disc_next = 1'b0;
                    acc_next  = '0;
                    pos_next  = '0;
                    pad_next  = PAD_NONE;
                end
            end
            else begin
                // first pad fixes the mode, only legal at positions 2 and 3
                if (cr.cls == CLS_PAD && pad_reg == PAD_NONE) begin
                    if (pos_reg == 2'd2)
                        pad_next = PAD_ONE;
                    else if (pos_reg == 2'd3)
                        pad_next = PAD_TWO;
                    else
                        pad_err = 1'b1;
                end

                if (cr.cls == CLS_INVALID || pad_err) begin
                    q_wr.push           = 1'b1;
                    q_wr.job.has_end    = 1'b1;
                    q_wr.job.end_status = pad_err ? ST_BAD_PAD : ST_BAD_SYMBOL;
                    pad_next            = pad_reg;
                    if (chars.final_req) begin
                        acc_next = '0;
                        pos_next = '0;
                        pad_next = PAD_NONE;
                    end
                    else begin
                        disc_next = 1'b1;
                    end
                end
                else begin
                    if (cr.cls == CLS_VALUE || cr.cls == CLS_PAD) begin
                        if (pos_reg == 2'd3) begin
                            unique case (pad_next)
                                PAD_ONE: q_wr.job.nbytes = 2'd1;
                                PAD_TWO: q_wr.job.nbytes = 2'd2;
                                default: q_wr.job.nbytes = 2'd3;
                            endcase
                            q_wr.push = 1'b1;
                            acc_next  = '0;
                            pos_next  = '0;
                        end
                        else begin
                            acc_next = acc_shift;
                            pos_next = pos_reg + 2'd1;
                        end
                    end
                    if (chars.final_req) begin
                        q_wr.push           = 1'b1;
                        q_wr.job.has_end    = 1'b1;
                        q_wr.job.end_status = (pos_next != 2'd0) ? ST_BAD_END : ST_END_OK;
                        acc_next            = '0;
                        pos_next            = '0;
                        pad_next            = PAD_NONE;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            acc_reg  <= '0;
            pos_reg  <= '0;
            pad_reg  <= PAD_NONE;
            disc_reg <= 1'b0;
        end
        else begin
            acc_reg  <= acc_next;
            pos_reg  <= pos_next;
            pad_reg  <= pad_next;
            disc_reg <= disc_next;
        end
    end

    assign stat.accept     = accept;
    assign stat.discarding = disc_reg;

endmodule

>>> rtl/bsd_queue.sv
module bsd_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  bsd_pkg::q_wr_t q_wr,
    input  logic           pop,
    output bsd_pkg::q_rd_t q_rd
);
    import bsd_pkg::*;

    job_t mem [QueueDepth];

    logic [QueuePtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QueuePtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QueuePtrW:0]   count_reg, count_next;
    logic                 do_push, do_pop;

    assign q_rd.empty = (count_reg == '0);
    assign q_rd.full  = (count_reg == (QueuePtrW+1)'(QueueDepth));
    assign q_rd.head  = mem[rd_ptr_reg];

    assign do_push = q_wr.push && !q_rd.full;
    assign do_pop  = pop && !q_rd.empty;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + QueuePtrW'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + QueuePtrW'(1) : rd_ptr_reg;
        count_next  = count_reg + (QueuePtrW+1)'(do_push) - (QueuePtrW+1)'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= q_wr.job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> rtl/bsd_back.sv
module bsd_back (
    input  logic           clk,
    input  logic           rst_n,
    input  bsd_pkg::q_rd_t q_rd,
    output logic           pop,
    bsd_res_if.source      results
);
    import bsd_pkg::*;

    logic [1:0] idx_reg, idx_next;
    logic       valid_reg, valid_next;
    logic [7:0] byte_reg, byte_next;
    status_t    status_reg, status_next;
    logic       last_reg, last_next;

    logic       load;
    logic [2:0] total;
    logic       is_last;

    assign load    = !valid_reg || results.ready;
    assign total   = {1'b0, q_rd.head.nbytes} + {2'b00, q_rd.head.has_end};
    assign is_last = ({1'b0, idx_reg} + 3'd1) == total;

    always_comb
    begin
        idx_next    = idx_reg;
        valid_next  = valid_reg;
        byte_next   = byte_reg;
        status_next = status_reg;
        last_next   = last_reg;
        pop         = 1'b0;
        if (load) begin
            valid_next = !q_rd.empty;
            if (!q_rd.empty) begin
                // data bytes first, most significant first, then any status
                if (idx_reg < q_rd.head.nbytes) begin
                    unique case (idx_reg)
                        2'd0:    byte_next = q_rd.head.bytes[23:16];
                        2'd1:    byte_next = q_rd.head.bytes[15:8];
                        default: byte_next = q_rd.head.bytes[7:0];
                    endcase
                    status_next = ST_DATA;
                end
                else begin
                    byte_next   = 8'd0;
                    status_next = q_rd.head.end_status;
                end
                last_next = is_last;
                if (is_last) begin
                    pop      = 1'b1;
                    idx_next = '0;
                end
                else begin
                    idx_next = idx_reg + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg   <= byte_next;
        status_reg <= status_next;
        last_reg   <= last_next;
    end

    assign results.valid       = valid_reg;
    assign results.out_byte    = byte_reg;
    assign results.status      = status_reg;
    assign results.last_of_run = last_reg;

endmodule

>>> rtl/base64_stream_decoder_unit.sv
// channel   dir  words                            payload
// chars     in   one character each               symbol[7:0], final_req
// results   out  one byte or status each          out_byte[7:0], status[2:0], last_of_run
//
// One character accepted per cycle while the 4-entry job queue has room.
// A character yields 0 to 4 results; the back end's output register sends one per
// cycle while results.ready holds, so a run of full groups is held to that rate.
// Results are written into the job queue and then into the output register before they appear.
// Asynchronous active-low reset clears decode state, queue and output valid.
module base64_stream_decoder_unit (
    input  logic      clk,
    input  logic      rst_n,
    bsd_sym_if.sink   chars,
    bsd_res_if.source results
);
    import bsd_pkg::*;

    q_wr_t       q_wr;
    q_rd_t       q_rd;
    logic        pop;
    front_stat_t fstat;

    bsd_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .chars (chars),
        .q_rd  (q_rd),
        .q_wr  (q_wr),
        .stat  (fstat)
    );

    bsd_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .q_wr  (q_wr),
        .pop   (pop),
        .q_rd  (q_rd)
    );

    bsd_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_rd    (q_rd),
        .pop     (pop),
        .results (results)
    );

    // a job is never offered to a full queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_wr.push |-> !q_rd.full)
        else $error("job pushed into full queue");

    // while discarding, characters produce nothing
    a_discard_silent: assert property (@(posedge clk) disable iff (!rst_n)
        fstat.accept && fstat.discarding |-> !q_wr.push)
        else $error("result produced while discarding");

    // status words always close a run
    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && !results.last_of_run |-> results.status == ST_DATA)
        else $error("status word not last of run");

    // queued jobs always carry at least one result
    a_job_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_wr.push |-> (q_wr.job.nbytes != 2'd0 || q_wr.job.has_end))
        else $error("empty job queued");

endmodule
